### src/lane_compaction_packing_buffer_top_macros.svh
// Assertion macros used by the lane compaction packing buffer checker.
`ifndef LANE_COMPACTION_PACKING_BUFFER_TOP_MACROS_SVH
`define LANE_COMPACTION_PACKING_BUFFER_TOP_MACROS_SVH

// Clocked assertion on i_clk, switched off while i_rst_n is low.
`define LCPB_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("lcpb checker: assertion failed");

// A signal must hold its value into the next cycle while a condition is true.
`define LCPB_ASSERT_HOLD(label, cond, sig) \
    `LCPB_ASSERT(label, (cond) |=> $stable(sig))

`endif

### src/lcpb_pkg.sv
// Types, constants and helpers for the lane compaction packing buffer.
`default_nettype none

package lcpb_pkg;

    localparam int LANES     = 8;
    localparam int LANE_BITS = 32;
    localparam int COUNT_W   = $clog2(LANES + 1);

    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_PURGE = 1'b1;

    typedef logic [LANE_BITS-1:0] t_lane;
    typedef t_lane [LANES-1:0]    t_lane_vec;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [COUNT_W:0]     t_sum;

    typedef struct packed {
        logic  action;
        t_lane lane0;
        t_lane lane1;
        t_lane lane2;
        t_lane lane3;
        t_lane lane4;
        t_lane lane5;
        t_lane lane6;
        t_lane lane7;
    } t_in_item;

    typedef struct packed {
        t_count out_count;
        t_lane  out0;
        t_lane  out1;
        t_lane  out2;
        t_lane  out3;
        t_lane  out4;
        t_lane  out5;
        t_lane  out6;
        t_lane  out7;
    } t_out_item;

    // Compactor result: nonzero lanes moved to the front, and how many there are.
    typedef struct packed {
        t_count    count;
        t_lane_vec lanes;
    } t_cmp_res;

    typedef struct packed {
        logic step;
        logic purge;
    } t_pack_ctl;

    function automatic t_lane_vec in_lanes(t_in_item it);
        t_lane_vec v;
        v[0] = it.lane0;
        v[1] = it.lane1;
        v[2] = it.lane2;
        v[3] = it.lane3;
        v[4] = it.lane4;
        v[5] = it.lane5;
        v[6] = it.lane6;
        v[7] = it.lane7;
        return v;
    endfunction

    function automatic t_out_item make_out(t_count count, t_lane_vec v);
        t_out_item o;
        o.out_count = count;
        o.out0      = v[0];
        o.out1      = v[1];
        o.out2      = v[2];
        o.out3      = v[3];
        o.out4      = v[4];
        o.out5      = v[5];
        o.out6      = v[6];
        o.out7      = v[7];
        return o;
    endfunction

endpackage

`default_nettype wire

### src/lcpb_compact.sv
// Lane compactor: moves the nonzero lanes of a vector to the front in lane order.
`default_nettype none

module lcpb_compact (
    input  lcpb_pkg::t_lane_vec i_lanes,
    output lcpb_pkg::t_cmp_res  o_res
);
    import lcpb_pkg::*;

    logic [LANES-1:0] nz;
    t_count           pos [LANES];
    t_count           total;
    t_lane_vec        packed_lanes;

    // Each nonzero lane goes to the slot given by the number of nonzero lanes below it.
    always_comb begin
        total = '0;
        for (int i = 0; i < LANES; i++) begin
            nz[i]  = |i_lanes[i];
            pos[i] = total;
            total  = total + t_count'(nz[i]);
        end
        for (int j = 0; j < LANES; j++) begin
            packed_lanes[j] = '0;
            for (int i = j; i < LANES; i++) begin
                if (nz[i] && pos[i] == t_count'(j)) begin
                    packed_lanes[j] = packed_lanes[j] | i_lanes[i];
                end
            end
        end
    end

    assign o_res.count = total;
    assign o_res.lanes = packed_lanes;

endmodule

`default_nettype wire

### src/lcpb_pack.sv
// Packing stage: holds the partial buffer and forms the result for one item.
`default_nettype none

module lcpb_pack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcpb_pkg::t_pack_ctl i_ctl,
    input  lcpb_pkg::t_cmp_res  i_cmp,
    output lcpb_pkg::t_out_item o_result
);
    import lcpb_pkg::*;

    t_lane_vec                          r_held;
    t_count                             r_hcount;
    t_lane_vec                          n_held;
    t_count                             n_hcount;
    logic [2*LANES-1:0][LANE_BITS-1:0] merged;
    t_sum                               sum;
    t_out_item                          result;

    // Held lanes followed by the compacted lanes. Slots above each count are zero,
    // so the two parts can be ORed together.
    always_comb begin
        for (int k = 0; k < 2 * LANES; k++) begin
            merged[k] = (k < LANES) ? r_held[k % LANES] : '0;
            for (int j = 0; j < LANES; j++) begin
                if (j <= k && k - j < LANES) begin
                    if (r_hcount == t_count'(k - j)) begin
                        merged[k] = merged[k] | i_cmp.lanes[j];
                    end
                end
            end
        end
    end

    assign sum = t_sum'(r_hcount) + t_sum'(i_cmp.count);

    always_comb begin
        n_held   = r_held;
        n_hcount = r_hcount;
        result   = make_out('0, '0);
        priority if (i_ctl.purge) begin
            result   = make_out(r_hcount, r_held);
            n_held   = '0;
            n_hcount = '0;
        end else if (i_cmp.count == t_count'(LANES)) begin
            // A vector with every lane in use goes out as it came and leaves
            // the buffer alone.
            result = make_out(t_count'(LANES), i_cmp.lanes);
        end else if (i_cmp.count == '0) begin
            result = make_out('0, '0);
        end else if (sum >= t_sum'(LANES)) begin
            result   = make_out(t_count'(LANES), merged[LANES-1:0]);
            n_held   = merged[2*LANES-1:LANES];
            n_hcount = t_count'(sum - t_sum'(LANES));
        end else begin
            n_held   = merged[LANES-1:0];
            n_hcount = sum[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_hcount <= '0;
        end else if (i_ctl.step) begin
            r_held   <= n_held;
            r_hcount <= n_hcount;
        end
    end

    assign o_result = result;

endmodule

`default_nettype wire

### src/lane_compaction_packing_buffer_top.sv
// Lane compaction packing buffer top level: input register, compaction and
// packing logic, result register.
//
// Accepts one item per clock cycle while the output is not stalled, and returns
// exactly one result item for each, via the input and result registers. The held
// buffer is updated in the same cycle as an item moves into the result register,
// so the next item packed sees the updated buffer. Input ready stays high while a
// result waits, as long as the input register is free or moves on in that cycle.
// A result with out_count zero means nothing was emitted; lanes at or above
// out_count are zero.
`default_nettype none

module lane_compaction_packing_buffer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lcpb_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lcpb_pkg::t_out_item o_out_item
);
    import lcpb_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      n_in_valid;
    logic      n_out_valid;
    logic      advance;
    t_cmp_res  cmp;
    t_pack_ctl ctl;
    t_out_item result;

    // The result register can take a new item when empty or being drained.
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    assign ctl.step  = r_in_valid && advance;
    assign ctl.purge = r_in.action == ACT_PURGE;

    assign n_in_valid  = o_in_ready ? i_in_valid : r_in_valid;
    assign n_out_valid = advance ? r_in_valid : r_out_valid;

    lcpb_compact u_compact (
        .i_lanes (in_lanes(r_in)),
        .o_res   (cmp)
    );

    lcpb_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_cmp    (cmp),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (ctl.step) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

### src/lcpb_checker.sv
// Port-level checker for the lane compaction packing buffer, with its bind.
`default_nettype none

`include "lane_compaction_packing_buffer_top_macros.svh"

module lcpb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input lcpb_pkg::t_out_item o_out_item
);
    import lcpb_pkg::*;

    logic out_empty;
    logic out_full;

    assign out_empty = o_out_valid && o_out_item.out_count == '0;
    assign out_full  = o_out_valid && o_out_item.out_count == t_count'(LANES);

    `LCPB_ASSERT(a_out_valid_holds, o_out_valid && !i_out_ready |=> o_out_valid)
    `LCPB_ASSERT_HOLD(a_out_item_holds, o_out_valid && !i_out_ready, o_out_item)
    `LCPB_ASSERT(a_count_in_range, o_out_valid |-> o_out_item.out_count <= t_count'(LANES))
    `LCPB_ASSERT(a_empty_result_zero, out_empty |-> (o_out_item.out0 | o_out_item.out7) == '0)
    `LCPB_ASSERT(a_full_result_dense, out_full |-> o_out_item.out0 != '0 && o_out_item.out7 != '0)

endmodule

bind lane_compaction_packing_buffer_top lcpb_checker u_checker (.*);

`default_nettype wire

### verif/lane_compaction_packing_buffer_top_test.sv
// Self-checking testbench for the lane compaction packing buffer top level.
`timescale 1ns / 1ps

module lane_compaction_packing_buffer_top_test;

    import lcpb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1150;
    localparam int QUIET_TAIL     = 150;
    localparam int REPORT_MAX     = 10;

    localparam t_out_item NOTHING_OUT = '0;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // Shadow copy of the partial buffer held inside the block.
    t_lane_vec held_buf;
    int        held_cnt;

    t_out_item result_q[$];
    t_stim_row dir_rows[$];
    int        mismatch_cnt;
    bit        idle_enable;
    int        out_stall_left;

    lane_compaction_packing_buffer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_in_item mk_item(logic act, t_lane l0, t_lane l1, t_lane l2,
                                         t_lane l3, t_lane l4, t_lane l5, t_lane l6,
                                         t_lane l7);
        t_in_item it;
        it.action = act;
        it.lane0  = l0;
        it.lane1  = l1;
        it.lane2  = l2;
        it.lane3  = l3;
        it.lane4  = l4;
        it.lane5  = l5;
        it.lane6  = l6;
        it.lane7  = l7;
        return it;
    endfunction

    function automatic t_lane_vec lanes_of(t_in_item it);
        t_lane_vec v;
        v = {it.lane7, it.lane6, it.lane5, it.lane4, it.lane3, it.lane2, it.lane1, it.lane0};
        return v;
    endfunction

    function automatic t_out_item pack_result(t_count cnt, t_lane_vec v);
        t_out_item o;
        o.out_count = cnt;
        o.out0      = v[0];
        o.out1      = v[1];
        o.out2      = v[2];
        o.out3      = v[3];
        o.out4      = v[4];
        o.out5      = v[5];
        o.out6      = v[6];
        o.out7      = v[7];
        return o;
    endfunction

    // Computes the packed vector an item produces and advances the shadow buffer.
    function automatic t_out_item predict_packed(t_in_item it);
        t_lane_vec src;
        t_lane_vec comp;
        t_lane_vec outv;
        t_count    cnt;
        int        n;
        int        take;
        src  = lanes_of(it);
        comp = '0;
        outv = '0;
        n    = 0;
        if (it.action == ACT_PURGE) begin
            for (int i = 0; i < held_cnt; i++) outv[i] = held_buf[i];
            cnt      = t_count'(held_cnt);
            held_buf = '0;
            held_cnt = 0;
            return pack_result(cnt, outv);
        end
        for (int i = 0; i < LANES; i++) begin
            if (src[i] != '0) begin
                comp[n] = src[i];
                n++;
            end
        end
        if (n == LANES) return pack_result(t_count'(LANES), comp);
        if (n == 0) return NOTHING_OUT;
        if (held_cnt + n >= LANES) begin
            take = LANES - held_cnt;
            for (int i = 0; i < LANES; i++) begin
                if (i < held_cnt) outv[i] = held_buf[i];
                else outv[i] = comp[i - held_cnt];
            end
            held_buf = '0;
            for (int i = take; i < n; i++) held_buf[i - take] = comp[i];
            held_cnt = held_cnt + n - LANES;
            return pack_result(t_count'(LANES), outv);
        end
        for (int i = 0; i < n; i++) held_buf[held_cnt + i] = comp[i];
        held_cnt = held_cnt + n;
        return NOTHING_OUT;
    endfunction

    function automatic t_lane rand_lane();
        t_lane w;
        case ($urandom_range(0, 7))
            0: w = '1;
            1: w = t_lane'(1);
            2: w = t_lane'(1) << (LANE_BITS - 1);
            default: begin
                w = $urandom;
                if (w == '0) w = t_lane'(1);
            end
        endcase
        return w;
    endfunction

    // Mostly partial vectors so the buffer wraps often; some full, empty and purges.
    function automatic t_in_item rand_item();
        t_lane_vec v;
        int        sel;
        int        mask;
        t_in_item  it;
        sel = $urandom_range(0, 99);
        v   = '0;
        if (sel < 12) begin
            for (int i = 0; i < LANES; i++) v[i] = ($urandom_range(0, 2) == 0) ? '0 : $urandom;
            it        = mk_item(ACT_PURGE, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
        end else begin
            if (sel < 20) mask = 255;
            else if (sel < 26) mask = 0;
            else mask = $urandom_range(1, 254);
            for (int i = 0; i < LANES; i++) if (mask[i]) v[i] = rand_lane();
            it = mk_item(ACT_PUSH, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
        end
        return it;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item pred;
        int        gap;
        if (idle_enable && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pred = predict_packed(it);
        result_q.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        wait (result_q.size() == 0);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!idle_enable) begin
            i_out_ready <= 1'b1;
        end else if (out_stall_left != 0) begin
            out_stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 11) == 0) begin
            out_stall_left = $urandom_range(0, 17);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("unexpected result item: count %0d", o_out_item.out_count);
            end else begin
                want = result_q.pop_front();
                if (want.out_count !== o_out_item.out_count)
                    note_mismatch("out_count", 32'(want.out_count), 32'(o_out_item.out_count));
                if (want.out0 !== o_out_item.out0) note_mismatch("out0", want.out0, o_out_item.out0);
                if (want.out1 !== o_out_item.out1) note_mismatch("out1", want.out1, o_out_item.out1);
                if (want.out2 !== o_out_item.out2) note_mismatch("out2", want.out2, o_out_item.out2);
                if (want.out3 !== o_out_item.out3) note_mismatch("out3", want.out3, o_out_item.out3);
                if (want.out4 !== o_out_item.out4) note_mismatch("out4", want.out4, o_out_item.out4);
                if (want.out5 !== o_out_item.out5) note_mismatch("out5", want.out5, o_out_item.out5);
                if (want.out6 !== o_out_item.out6) note_mismatch("out6", want.out6, o_out_item.out6);
                if (want.out7 !== o_out_item.out7) note_mismatch("out7", want.out7, o_out_item.out7);
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        t_lane ones;
        t_lane msb;
        ones         = '1;
        msb          = t_lane'(1) << (LANE_BITS - 1);
        held_buf     = '0;
        held_cnt     = 0;
        mismatch_cnt = 0;
        idle_enable  = 1'b1;

        // Purge of an empty buffer and an all-empty vector both emit nothing.
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PURGE, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1'b1, NOTHING_OUT});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PUSH, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1'b1, NOTHING_OUT});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PUSH, ones, ones, ones, ones, ones, ones,
                                               ones, ones), 1'b1,
                                       pack_result(t_count'(LANES), {LANES{ones}})});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PUSH, 1, 2, 3, 4, 5, 6, 7, 8), 1'b1,
                                       pack_result(t_count'(LANES),
                                                   lanes_of(mk_item(ACT_PUSH, 1, 2, 3, 4,
                                                                    5, 6, 7, 8)))});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PUSH, 0, 0, 0, 0, 0, 0, 0, ones),
                                       1'b0, NOTHING_OUT});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PUSH, 1, 0, 0, 0, 0, 0, 0, 0),
                                       1'b0, NOTHING_OUT});
        // A full vector bypasses the lanes already held.
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PUSH, msb, 9, 10, 11, 12, 13, 14, ones),
                                       1'b1,
                                       pack_result(t_count'(LANES),
                                                   lanes_of(mk_item(ACT_PUSH, msb, 9, 10, 11,
                                                                    12, 13, 14, ones)))});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PURGE, ones, 0, ones, 0, 0, 0, 0, 0),
                                       1'b0, NOTHING_OUT});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PURGE, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1'b1, NOTHING_OUT});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PUSH, 21, 22, 23, 0, 25, 26, 27, 28),
                                       1'b0, NOTHING_OUT});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PUSH, 0, 32, 33, 34, 35, 36, 37, 38),
                                       1'b0, NOTHING_OUT});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PUSH, 0, 41, 0, 0, 42, 0, 0, 0),
                                       1'b0, NOTHING_OUT});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PUSH, 51, 0, 52, 0, 53, 0, 54, 0),
                                       1'b0, NOTHING_OUT});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PUSH, 0, 61, 62, 63, 0, 64, 65, 0),
                                       1'b0, NOTHING_OUT});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PURGE, 0, 0, 0, 0, 0, 0, 0, 0),
                                       1'b0, NOTHING_OUT});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PUSH, 0, 0, 0, msb, 0, 0, 0, 0),
                                       1'b0, NOTHING_OUT});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PUSH, ones, ones, ones, ones, ones, ones,
                                               ones, 0), 1'b0, NOTHING_OUT});
        dir_rows.push_back(t_stim_row'{mk_item(ACT_PURGE, ones, ones, ones, ones, ones, ones,
                                               ones, ones), 1'b0, NOTHING_OUT});

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
        drain_results();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 100 == 0) idle_enable = ($urandom_range(0, 3) != 0);
            if (k >= RANDOM_ITEMS - QUIET_TAIL) idle_enable = 1'b0;
            if (k == RANDOM_ITEMS / 2) drain_results();
            send_item(rand_item(), 1'b0, NOTHING_OUT);
        end

        i_in_valid <= 1'b0;
        wait (result_q.size() == 0);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
